FILE: rtl/bmft_pkg.sv
package bmft_pkg;

    localparam int SEC_W = 6;
    localparam int SEC_N = 64;
    localparam int LBN_W = 5;
    localparam int OFF_W = 4;
    localparam int CMD_W = 3;
    localparam int PAGE_W = 6;
    localparam int BLK_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ     = 3'd0,
        CMD_PROGRAM  = 3'd1,
        CMD_COPY     = 3'd2,
        CMD_ERASE    = 3'd3,
        CMD_UNMAPPED = 3'd4
    } t_cmd_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_MAPRD,
        S_RDOUT,
        S_ROWRD,
        S_ROWCHK,
        S_CPOUT,
        S_ERASE_DATA,
        S_PROG,
        S_CPBACK,
        S_ERASE_SPARE
    } t_state_e;

    typedef struct packed {
        logic             opcode;
        logic [SEC_W-1:0] sector_number;
    } t_req_s;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PAGE_W-1:0] page_address;
        logic [PAGE_W-1:0] copy_target;
        logic [BLK_W-1:0]  erase_target;
        logic [SEC_W-1:0]  spare_tag;
        logic              last;
    } t_cmd_s;

    typedef struct packed {
        logic             write;
        logic             in_range;
        logic [SEC_W-1:0] sector;
        logic [LBN_W-1:0] lbn;
        logic [OFF_W-1:0] offset;
    } t_cls_s;

endpackage

FILE: rtl/block_mapped_flash_translation_top.sv
// channel    direction  handshake                   payload
// request    in         i_req_valid / o_req_ready   i_req  (opcode, sector_number)
// command    out        o_cmd_valid / i_cmd_ready   o_cmd  (zero, one or more commands)
//
// read request: one read command, or an unmapped command when the block is unmapped
// write to empty page: one program command; overwrite: 2*PAGES_PER_BLK + 2 commands
// front stage and 2-entry queue take new requests while the sequencer works
// synchronous active-low reset clears maps, page-row valid bits and all handshake state
// a stalled command holds the sequencer; a full queue with the front stage held drops o_req_ready
module block_mapped_flash_translation_top #(
    parameter int PAGES_PER_BLK  = 4,
    parameter int LOGICAL_BLOCKS = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  bmft_pkg::t_req_s i_req,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output bmft_pkg::t_cmd_s o_cmd
);
    import bmft_pkg::*;

    logic   w_f_valid;
    logic   w_f_ready;
    t_cls_s w_f_cls;
    logic   w_q_valid;
    logic   w_q_ready;
    t_cls_s w_q_cls;

    bmft_front #(
        .PAGES_PER_BLK  (PAGES_PER_BLK),
        .LOGICAL_BLOCKS (LOGICAL_BLOCKS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_cls_valid (w_f_valid),
        .i_cls_ready (w_f_ready),
        .o_cls       (w_f_cls)
    );

    bmft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_cls),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_cls)
    );

    bmft_back #(
        .PAGES_PER_BLK  (PAGES_PER_BLK),
        .LOGICAL_BLOCKS (LOGICAL_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .i_q_data    (w_q_cls),
        .o_cmd_valid (o_cmd_valid),
        .i_cmd_ready (i_cmd_ready),
        .o_cmd       (o_cmd)
    );

endmodule

FILE: rtl/bmft_ram.sv
module bmft_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 15
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bmft_front.sv
module bmft_front #(
    parameter int PAGES_PER_BLK  = 4,
    parameter int LOGICAL_BLOCKS = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  bmft_pkg::t_req_s i_req,
    output logic             o_cls_valid,
    input  logic             i_cls_ready,
    output bmft_pkg::t_cls_s o_cls
);
    import bmft_pkg::*;

    logic [LBN_W-1:0] w_lbn_tab [SEC_N];
    logic [OFF_W-1:0] w_off_tab [SEC_N];
    logic             r_vld;
    t_cls_s           r_cls;
    t_cls_s           n_cls;
    logic             w_accept;

    // constant divide and remainder tables over all sector codes
    for (genvar g = 0; g < SEC_N; g++) begin : g_tab
        assign w_lbn_tab[g] = LBN_W'(g / PAGES_PER_BLK);
        assign w_off_tab[g] = OFF_W'(g % PAGES_PER_BLK);
    end

    assign o_req_ready = !r_vld || i_cls_ready;
    assign w_accept    = i_req_valid && o_req_ready;

    always_comb begin
        n_cls.write    = i_req.opcode;
        n_cls.sector   = i_req.sector_number;
        n_cls.lbn      = w_lbn_tab[i_req.sector_number];
        n_cls.offset   = w_off_tab[i_req.sector_number];
        n_cls.in_range = ({2'b00, w_lbn_tab[i_req.sector_number]} < 7'(LOGICAL_BLOCKS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (i_cls_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cls <= n_cls;
        end
    end

    assign o_cls_valid = r_vld;
    assign o_cls       = r_cls;

endmodule

FILE: rtl/bmft_queue.sv
module bmft_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bmft_pkg::t_cls_s i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output bmft_pkg::t_cls_s o_data
);
    import bmft_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    t_cls_s        r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != (PW + 1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/bmft_back.sv
module bmft_back #(
    parameter int PAGES_PER_BLK  = 4,
    parameter int LOGICAL_BLOCKS = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_ready,
    input  bmft_pkg::t_cls_s i_q_data,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output bmft_pkg::t_cmd_s o_cmd
);
    import bmft_pkg::*;

    localparam int PBW = (LOGICAL_BLOCKS > 1) ? $clog2(LOGICAL_BLOCKS) : 1;
    localparam int CW  = $clog2(LOGICAL_BLOCKS + 1);
    localparam int OFW = $clog2(PAGES_PER_BLK);
    localparam int PAW = $clog2((LOGICAL_BLOCKS + 1) * PAGES_PER_BLK);
    localparam logic [PAW-1:0] SPARE_BASE = PAW'(LOGICAL_BLOCKS * PAGES_PER_BLK);
    localparam logic [OFW-1:0] IDX_LAST   = OFW'(PAGES_PER_BLK - 1);

    t_state_e                  r_state;
    t_state_e                  n_state;
    t_cls_s                    r_req;
    logic [PBW-1:0]            r_pbn;
    logic [OFW-1:0]            r_idx;
    logic [CW-1:0]             r_alloc;
    logic [LOGICAL_BLOCKS-1:0] r_map_vld;
    logic [LOGICAL_BLOCKS-1:0] r_row_vld;
    logic                      r_out_vld;
    t_cmd_s                    r_out;

    logic [PBW-1:0]           w_lbn;
    logic [OFW-1:0]           w_off;
    logic                     w_mapped;
    logic [PAGES_PER_BLK-1:0] w_page_rdata;
    logic [PAGES_PER_BLK-1:0] w_row;
    logic [PAGES_PER_BLK-1:0] w_page_wdata;
    logic [PBW-1:0]           w_map_rdata;
    logic [PAW-1:0]           w_base;
    logic                     w_out_free;
    logic                     w_cp_step;
    logic                     w_emit;
    t_cmd_s                   w_cmd;
    logic                     w_map_re;
    logic                     w_alloc;
    logic                     w_page_re;
    logic                     w_page_we;

    assign w_lbn        = PBW'(r_req.lbn);
    assign w_off        = r_req.offset[OFW-1:0];
    assign w_mapped     = r_req.in_range && r_map_vld[w_lbn];
    assign w_row        = r_row_vld[r_pbn] ? w_page_rdata : '0;
    assign w_page_wdata = w_row | ({{(PAGES_PER_BLK - 1){1'b0}}, 1'b1} << w_off);
    assign w_base       = PAW'(r_pbn) * PAW'(PAGES_PER_BLK);
    assign w_out_free   = !r_out_vld || i_cmd_ready;
    assign w_cp_step    = (r_idx == w_off) || w_out_free;

    bmft_ram #(
        .WIDTH (PBW),
        .DEPTH (LOGICAL_BLOCKS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_alloc),
        .i_waddr (w_lbn),
        .i_wdata (PBW'(r_alloc)),
        .i_re    (w_map_re),
        .i_raddr (w_lbn),
        .o_rdata (w_map_rdata)
    );

    bmft_ram #(
        .WIDTH (PAGES_PER_BLK),
        .DEPTH (LOGICAL_BLOCKS)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (w_page_we),
        .i_waddr (r_pbn),
        .i_wdata (w_page_wdata),
        .i_re    (w_page_re),
        .i_raddr (r_pbn),
        .o_rdata (w_page_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (!r_req.write) begin
                    if (!w_mapped) begin
                        if (w_out_free) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_MAPRD;
                    end
                end else if (!r_req.in_range) begin
                    n_state = S_IDLE;
                end else if (!w_mapped) begin
                    n_state = S_ROWRD;
                end else begin
                    n_state = S_MAPRD;
                end
            end
            S_MAPRD: begin
                n_state = r_req.write ? S_ROWRD : S_RDOUT;
            end
            S_RDOUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ROWRD: begin
                n_state = S_ROWCHK;
            end
            S_ROWCHK: begin
                if (w_row[w_off]) begin
                    n_state = S_CPOUT;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CPOUT: begin
                if (w_out_free && r_idx == IDX_LAST) begin
                    n_state = S_ERASE_DATA;
                end
            end
            S_ERASE_DATA: begin
                if (w_out_free) begin
                    n_state = S_PROG;
                end
            end
            S_PROG: begin
                if (w_out_free) begin
                    n_state = S_CPBACK;
                end
            end
            S_CPBACK: begin
                if (w_cp_step && r_idx == IDX_LAST) begin
                    n_state = S_ERASE_SPARE;
                end
            end
            S_ERASE_SPARE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_emit    = 1'b0;
        w_cmd     = '0;
        o_q_ready = 1'b0;
        w_map_re  = 1'b0;
        w_alloc   = 1'b0;
        w_page_re = 1'b0;
        w_page_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_q_ready = 1'b1;
            end
            S_CLASS: begin
                if (!r_req.write) begin
                    if (!w_mapped) begin
                        w_emit        = w_out_free;
                        w_cmd.command = CMD_UNMAPPED;
                        w_cmd.last    = 1'b1;
                    end else begin
                        w_map_re = 1'b1;
                    end
                end else if (r_req.in_range) begin
                    if (!w_mapped) begin
                        w_alloc = 1'b1;
                    end else begin
                        w_map_re = 1'b1;
                    end
                end
            end
            S_RDOUT: begin
                w_emit             = w_out_free;
                w_cmd.command      = CMD_READ;
                w_cmd.page_address = PAGE_W'(w_base + PAW'(w_off));
                w_cmd.last         = 1'b1;
            end
            S_ROWRD: begin
                w_page_re = 1'b1;
            end
            S_ROWCHK: begin
                if (!w_row[w_off]) begin
                    w_emit             = w_out_free;
                    w_page_we          = w_out_free;
                    w_cmd.command      = CMD_PROGRAM;
                    w_cmd.page_address = PAGE_W'(w_base + PAW'(w_off));
                    w_cmd.spare_tag    = r_req.sector;
                    w_cmd.last         = 1'b1;
                end
            end
            S_CPOUT: begin
                w_emit             = w_out_free;
                w_cmd.command      = CMD_COPY;
                w_cmd.page_address = PAGE_W'(w_base + PAW'(r_idx));
                w_cmd.copy_target  = PAGE_W'(SPARE_BASE + PAW'(r_idx));
            end
            S_ERASE_DATA: begin
                w_emit             = w_out_free;
                w_cmd.command      = CMD_ERASE;
                w_cmd.erase_target = BLK_W'(r_pbn);
            end
            S_PROG: begin
                w_emit             = w_out_free;
                w_cmd.command      = CMD_PROGRAM;
                w_cmd.page_address = PAGE_W'(w_base + PAW'(w_off));
                w_cmd.spare_tag    = r_req.sector;
            end
            S_CPBACK: begin
                if (r_idx != w_off) begin
                    w_emit             = w_out_free;
                    w_cmd.command      = CMD_COPY;
                    w_cmd.page_address = PAGE_W'(SPARE_BASE + PAW'(r_idx));
                    w_cmd.copy_target  = PAGE_W'(w_base + PAW'(r_idx));
                end
            end
            S_ERASE_SPARE: begin
                w_emit             = w_out_free;
                w_cmd.command      = CMD_ERASE;
                w_cmd.erase_target = BLK_W'(LOGICAL_BLOCKS);
                w_cmd.last         = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_alloc   <= '0;
            r_map_vld <= '0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_alloc) begin
                r_alloc          <= r_alloc + 1'b1;
                r_map_vld[w_lbn] <= 1'b1;
            end
            if (w_page_we) begin
                r_row_vld[r_pbn] <= 1'b1;
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_cmd_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_ready && i_q_valid) begin
            r_req <= i_q_data;
        end
        if (w_alloc) begin
            r_pbn <= PBW'(r_alloc);
        end else if (r_state == S_MAPRD) begin
            r_pbn <= w_map_rdata;
        end
        if (r_state == S_ROWCHK || r_state == S_PROG) begin
            r_idx <= '0;
        end else if ((r_state == S_CPOUT && w_out_free) ||
                     (r_state == S_CPBACK && w_cp_step)) begin
            r_idx <= r_idx + 1'b1;
        end
        if (w_emit) begin
            r_out <= w_cmd;
        end
    end

    assign o_cmd_valid = r_out_vld;
    assign o_cmd       = r_out;

endmodule
